// ===== hdl/slkt_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted leaf key table package
// Sizes, operation and status codes, and the stored entry type shared by the
// table core and its compare unit.
// ---------------------------------------------------------------------------
package slkt_pkg;

    localparam int CAPACITY  = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int OUT_CNT_W = 6;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_FROM   = 3'd3;
    localparam logic [2:0] OP_UNTIL  = 3'd4;
    localparam logic [2:0] OP_ALL    = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PRESENT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

endpackage

// ===== hdl/slkt_cmp.sv =====
// ---------------------------------------------------------------------------
// Sorted leaf key table compare unit
// Shared signed key comparator used for every search step of the table.
// ---------------------------------------------------------------------------
module slkt_cmp
    import slkt_pkg::*;
(
    input  logic signed [KEY_W-1:0] i_a,
    input  logic signed [KEY_W-1:0] i_b,
    output logic                    o_lt,
    output logic                    o_eq
);

    assign o_lt = i_a < i_b;
    assign o_eq = i_a == i_b;

endmodule

// ===== hdl/sorted_leaf_key_table_core.sv =====
// ---------------------------------------------------------------------------
// Sorted leaf key table core
// Key-sorted table of key/value entries with insert, lookup, remove and
// range reads, run by a small sequencer over one entry memory.
//
//   Channel   Valid        Stall        Payload
//   input     i_in_valid   o_in_stall   i_opcode, i_key, i_value
//   output    o_out_valid  i_out_stall  o_status, o_entry_valid, o_key_out,
//                                       o_value_out, o_entry_count, o_last
//
// A lookup scans the held entries with one memory read per cycle into the shared
// comparator until a hit or the last entry, then passes through decide and result.
// Insert and remove shift each moved entry through a read and a write state, and
// insert then writes the new entry; each range result passes a read and a load state
// after decide, range all skips the scan, and a stalled output holds the sequencer.
// Reset clears the entry count, the sequencer and the output valid; the memory needs no clear.
// The input is stalled until an operation has loaded its last result into the
// output register, and that result then waits there while the next transfer is taken.
// ---------------------------------------------------------------------------
module sorted_leaf_key_table_core
    import slkt_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_opcode,
    input  logic signed [KEY_W-1:0]     i_key,
    input  logic signed [VAL_W-1:0]     i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic                        o_entry_valid,
    output logic signed [KEY_W-1:0]     o_key_out,
    output logic signed [VAL_W-1:0]     o_value_out,
    output logic [OUT_CNT_W-1:0]        o_entry_count,
    output logic                        o_last
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_FIND    = 11'b000_0000_0010,
        S_DECIDE  = 11'b000_0000_0100,
        S_ISH_RD  = 11'b000_0000_1000,
        S_ISH_WR  = 11'b000_0001_0000,
        S_INS_WR  = 11'b000_0010_0000,
        S_RSH_RD  = 11'b000_0100_0000,
        S_RSH_WR  = 11'b000_1000_0000,
        S_EMIT_RD = 11'b001_0000_0000,
        S_EMIT_LD = 11'b010_0000_0000,
        S_RESP    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [2:0]             r_op, n_op;
    logic [KEY_W-1:0]       r_key, n_key;
    logic [VAL_W-1:0]       r_val, n_val;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_scan_idx, n_scan_idx;
    logic                   r_dv, n_dv;
    logic [CNT_W-1:0]       r_dv_idx, n_dv_idx;
    logic [CNT_W-1:0]       r_pos, n_pos;
    logic                   r_eq, n_eq;
    logic [CNT_W-1:0]       r_j, n_j;
    logic [CNT_W-1:0]       r_hi, n_hi;
    logic [1:0]             r_res_status, n_res_status;
    logic                   r_res_valid, n_res_valid;
    logic [KEY_W-1:0]       r_res_key, n_res_key;
    logic [VAL_W-1:0]       r_res_val, n_res_val;

    logic                   r_out_valid, n_out_valid;
    logic [1:0]             r_out_status, n_out_status;
    logic                   r_out_entry_valid, n_out_entry_valid;
    logic [KEY_W-1:0]       r_out_key, n_out_key;
    logic [VAL_W-1:0]       r_out_val, n_out_val;
    logic [OUT_CNT_W-1:0]   r_out_count, n_out_count;
    logic                   r_out_last, n_out_last;

    t_entry                 r_mem [CAPACITY];
    t_entry                 r_rdata;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    t_entry                 wr_data;

    logic                   cmp_lt;
    logic                   cmp_eq;
    logic                   hit;
    logic                   out_free;
    logic [CNT_W-1:0]       j_dec;
    logic [CNT_W-1:0]       j_inc;
    logic [CNT_W-1:0]       range_lo;
    logic [CNT_W-1:0]       range_hi;

    slkt_cmp u_cmp (
        .i_a  ($signed(r_rdata.key)),
        .i_b  ($signed(r_key)),
        .o_lt (cmp_lt),
        .o_eq (cmp_eq)
    );

    assign hit      = (r_op == OP_UNTIL) ? (!cmp_lt && !cmp_eq) : !cmp_lt;
    assign out_free = !r_out_valid || !i_out_stall;
    assign j_dec    = r_j - CNT_W'(1);
    assign j_inc    = r_j + CNT_W'(1);

    always_comb begin
        range_lo = '0;
        range_hi = r_count;
        case (r_op)
            OP_FROM: begin
                range_lo = r_pos;
            end
            OP_UNTIL: begin
                range_hi = r_pos;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state           = r_state;
        n_op              = r_op;
        n_key             = r_key;
        n_val             = r_val;
        n_count           = r_count;
        n_scan_idx        = r_scan_idx;
        n_dv              = 1'b0;
        n_dv_idx          = r_dv_idx;
        n_pos             = r_pos;
        n_eq              = r_eq;
        n_j               = r_j;
        n_hi              = r_hi;
        n_res_status      = r_res_status;
        n_res_valid       = r_res_valid;
        n_res_key         = r_res_key;
        n_res_val         = r_res_val;
        n_out_valid       = r_out_valid && i_out_stall;
        n_out_status      = r_out_status;
        n_out_entry_valid = r_out_entry_valid;
        n_out_key         = r_out_key;
        n_out_val         = r_out_val;
        n_out_count       = r_out_count;
        n_out_last        = r_out_last;
        rd_en             = 1'b0;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_opcode;
                    n_key      = i_key;
                    n_val      = i_value;
                    n_scan_idx = '0;
                    if (i_opcode inside {OP_INSERT, OP_LOOKUP, OP_REMOVE, OP_FROM,
                                         OP_UNTIL}) begin
                        n_state = S_FIND;
                    end else if (i_opcode == OP_ALL) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_FIND: begin
                if (r_dv) begin
                    if (hit) begin
                        n_pos     = r_dv_idx;
                        n_eq      = cmp_eq;
                        n_res_key = r_rdata.key;
                        n_res_val = r_rdata.value;
                        n_state   = S_DECIDE;
                    end else if ((r_dv_idx + CNT_W'(1)) == r_count) begin
                        n_pos   = r_count;
                        n_eq    = 1'b0;
                        n_state = S_DECIDE;
                    end
                end else if (r_count == '0) begin
                    n_pos   = '0;
                    n_eq    = 1'b0;
                    n_state = S_DECIDE;
                end
                if (n_state == S_FIND && r_scan_idx < r_count) begin
                    rd_en      = 1'b1;
                    rd_addr    = r_scan_idx[IDX_W-1:0];
                    n_scan_idx = r_scan_idx + CNT_W'(1);
                    n_dv       = 1'b1;
                    n_dv_idx   = r_scan_idx;
                end
            end
            S_DECIDE: begin
                n_state = S_RESP;
                case (r_op)
                    OP_INSERT: begin
                        if (r_eq) begin
                            n_res_status = ST_PRESENT;
                            n_res_valid  = 1'b1;
                        end else if (r_count == CNT_W'(CAPACITY)) begin
                            n_res_status = ST_FULL;
                            n_res_valid  = 1'b0;
                            n_res_key    = '0;
                            n_res_val    = '0;
                        end else begin
                            n_j     = r_count;
                            n_state = (r_count == r_pos) ? S_INS_WR : S_ISH_RD;
                        end
                    end
                    OP_LOOKUP, OP_REMOVE: begin
                        if (r_eq) begin
                            n_res_status = ST_OK;
                            n_res_valid  = 1'b1;
                            if (r_op == OP_REMOVE) begin
                                n_j = r_pos;
                                if ((r_pos + CNT_W'(1)) < r_count) begin
                                    n_state = S_RSH_RD;
                                end else begin
                                    n_count = r_count - CNT_W'(1);
                                end
                            end
                        end else begin
                            n_res_status = ST_NOT_FOUND;
                            n_res_valid  = 1'b0;
                            n_res_key    = '0;
                            n_res_val    = '0;
                        end
                    end
                    OP_FROM, OP_UNTIL, OP_ALL: begin
                        if (range_lo >= range_hi) begin
                            n_res_status = ST_NOT_FOUND;
                            n_res_valid  = 1'b0;
                            n_res_key    = '0;
                            n_res_val    = '0;
                        end else begin
                            n_j     = range_lo;
                            n_hi    = range_hi;
                            n_state = S_EMIT_RD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ISH_RD: begin
                rd_en   = 1'b1;
                rd_addr = j_dec[IDX_W-1:0];
                n_state = S_ISH_WR;
            end
            S_ISH_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_j[IDX_W-1:0];
                wr_data = r_rdata;
                n_j     = j_dec;
                n_state = (j_dec == r_pos) ? S_INS_WR : S_ISH_RD;
            end
            S_INS_WR: begin
                wr_en         = 1'b1;
                wr_addr       = r_pos[IDX_W-1:0];
                wr_data.key   = r_key;
                wr_data.value = r_val;
                n_count       = r_count + CNT_W'(1);
                n_res_status  = ST_OK;
                n_res_valid   = 1'b1;
                n_res_key     = r_key;
                n_res_val     = r_val;
                n_state       = S_RESP;
            end
            S_RSH_RD: begin
                rd_en   = 1'b1;
                rd_addr = j_inc[IDX_W-1:0];
                n_state = S_RSH_WR;
            end
            S_RSH_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_j[IDX_W-1:0];
                wr_data = r_rdata;
                n_j     = j_inc;
                if ((j_inc + CNT_W'(1)) < r_count) begin
                    n_state = S_RSH_RD;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RESP;
                end
            end
            S_EMIT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_j[IDX_W-1:0];
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out_status      = ST_OK;
                    n_out_entry_valid = 1'b1;
                    n_out_key         = r_rdata.key;
                    n_out_val         = r_rdata.value;
                    n_out_count       = OUT_CNT_W'(r_count);
                    n_out_last        = (j_inc == r_hi);
                    if (j_inc == r_hi) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = j_inc;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out_status      = r_res_status;
                    n_out_entry_valid = r_res_valid;
                    n_out_key         = r_res_key;
                    n_out_val         = r_res_val;
                    n_out_count       = OUT_CNT_W'(r_count);
                    n_out_last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op              <= n_op;
        r_key             <= n_key;
        r_val             <= n_val;
        r_scan_idx        <= n_scan_idx;
        r_dv_idx          <= n_dv_idx;
        r_pos             <= n_pos;
        r_eq              <= n_eq;
        r_j               <= n_j;
        r_hi              <= n_hi;
        r_res_status      <= n_res_status;
        r_res_valid       <= n_res_valid;
        r_res_key         <= n_res_key;
        r_res_val         <= n_res_val;
        r_out_status      <= n_out_status;
        r_out_entry_valid <= n_out_entry_valid;
        r_out_key         <= n_out_key;
        r_out_val         <= n_out_val;
        r_out_count       <= n_out_count;
        r_out_last        <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_valid = r_out_entry_valid;
    assign o_key_out     = r_out_key;
    assign o_value_out   = r_out_val;
    assign o_entry_count = r_out_count;
    assign o_last        = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_invalid_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_entry_valid) |-> (r_out_status != ST_OK))
        else $error("result without entry reported as ok");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FULL) |->
        (!r_out_entry_valid && r_out_count == OUT_CNT_W'(CAPACITY)))
        else $error("full status with wrong entry or count");

    a_range_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !r_out_last) |-> (r_state != S_IDLE))
        else $error("range ended before its last transfer");

endmodule
